### sv/assert_macros.svh
// assertion helpers shared by the rle decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational check, sampled at every rising clock edge out of reset
`define TMRLE_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tmrle check failed");

// same-cycle implication
`define TMRLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmrle implication failed");

`endif

### sv/tmrle_pkg.sv
package tmrle_pkg;

    // decoder limits
    localparam int MAX_RUN  = 64;
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 32;
    localparam int RUN_W    = (MAX_RUN > 2) ? $clog2(MAX_RUN) : 1;

    // register reset values
    localparam logic        RST_COMPRESSED_MODE = 1'b1;
    localparam logic [5:0]  RST_ROW_COUNT       = 6'd28;
    localparam logic [6:0]  RST_COL_COUNT       = 7'd40;
    localparam logic [23:0] RST_BASE_ADDRESS    = 24'h10F030;
    localparam logic [10:0] RST_ROW_STRIDE      = 11'h080;

    typedef enum logic [2:0] {
        REG_COMPRESSED_MODE = 3'd0,
        REG_ROW_COUNT       = 3'd1,
        REG_COL_COUNT       = 3'd2,
        REG_BASE_ADDRESS    = 3'd3,
        REG_ROW_STRIDE      = 3'd4
    } t_reg_index;

    typedef enum logic [1:0] {
        PH_TOKEN = 2'd0,
        PH_VALUE = 2'd1,
        PH_COUNT = 2'd2
    } t_phase;

    // one decoded run: last_index is copies minus one
    typedef struct packed {
        logic [15:0]      tile;
        logic [RUN_W-1:0] last_index;
        logic             clipped;
    } t_cmd;

    typedef struct packed {
        logic [5:0]  row_count;
        logic [6:0]  col_count;
        logic [10:0] row_stride;
    } t_back_cfg;

    typedef struct packed {
        logic        valid;
        logic [23:0] base_address;
    } t_restart;

endpackage

### sv/tmrle_front.sv
module tmrle_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tmrle_pkg::t_restart i_restart,
    input  logic              i_compressed_mode,
    input  logic              i_map_valid,
    input  logic [15:0]       i_map_word,
    output logic              o_map_ready,
    input  logic              i_queue_full,
    output logic              o_push,
    output tmrle_pkg::t_cmd   o_cmd
);
    import tmrle_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_held, n_held;
    logic        accept;

    assign o_map_ready = !i_queue_full;
    assign accept      = i_map_valid && !i_queue_full;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        if (accept) begin
            if (!i_compressed_mode) begin
                n_phase = PH_TOKEN;
            end else begin
                case (r_phase)
                    PH_VALUE: begin
                        n_held  = i_map_word;
                        n_phase = PH_COUNT;
                    end
                    PH_COUNT: begin
                        n_phase = PH_TOKEN;
                    end
                    default: begin
                        n_phase = (i_map_word == 16'd0) ? PH_VALUE : PH_TOKEN;
                    end
                endcase
            end
        end
    end

    // command out
    always_comb begin
        o_push           = 1'b0;
        o_cmd.tile       = i_map_word;
        o_cmd.last_index = '0;
        o_cmd.clipped    = 1'b0;
        if (accept) begin
            if (!i_compressed_mode) begin
                o_push = 1'b1;
            end else begin
                case (r_phase)
                    PH_VALUE: begin
                        o_push = 1'b0;
                    end
                    PH_COUNT: begin
                        o_push     = 1'b1;
                        o_cmd.tile = r_held;
                        if (i_map_word > 16'(MAX_RUN - 1)) begin
                            o_cmd.last_index = RUN_W'(MAX_RUN - 1);
                            o_cmd.clipped    = 1'b1;
                        end else begin
                            o_cmd.last_index = i_map_word[RUN_W-1:0];
                        end
                    end
                    default: begin
                        o_push = (i_map_word != 16'd0);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart.valid) begin
            r_phase <= PH_TOKEN;
            r_held  <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

### sv/tmrle_queue.sv
`include "assert_macros.svh"

module tmrle_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_push,
    input  tmrle_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output tmrle_pkg::t_cmd o_cmd,
    output logic            o_empty,
    output logic            o_full
);
    import tmrle_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `TMRLE_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full && !i_pop))
    `TMRLE_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty))

endmodule

### sv/tmrle_back.sv
`include "assert_macros.svh"

module tmrle_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tmrle_pkg::t_restart  i_restart,
    input  tmrle_pkg::t_back_cfg i_cfg,
    input  tmrle_pkg::t_cmd      i_cmd,
    input  logic                 i_queue_empty,
    output logic                 o_pop,
    output logic                 o_tile_valid,
    input  logic                 i_tile_ready,
    output logic [23:0]          o_tile_address,
    output logic [15:0]          o_tile_word,
    output logic                 o_run_last,
    output logic                 o_map_done,
    output logic                 o_run_clipped
);
    import tmrle_pkg::*;

    // run in progress
    logic             r_busy;
    logic [15:0]      r_tile;
    logic [RUN_W-1:0] r_left;
    logic             r_clip;

    // map position
    logic [6:0]  r_column;
    logic [5:0]  r_row;
    logic [23:0] r_waddr, r_row_start;
    logic        r_finished;

    // output register
    logic        r_out_valid;
    logic [23:0] r_out_addr;
    logic [15:0] r_out_tile;
    logic        r_out_last, r_out_done, r_out_clip;

    logic             have, out_free, emit, last, row_end, map_last;
    logic [15:0]      cur_tile;
    logic [RUN_W-1:0] cur_left;
    logic             cur_clip;
    logic [6:0]       col_inc;
    logic [7:0]       eff_col;
    logic [6:0]       eff_row;
    logic [23:0]      next_start;

    assign have     = r_busy || !i_queue_empty;
    assign out_free = !r_out_valid || i_tile_ready;
    assign emit     = have && out_free && !r_finished;
    // after the map, queued runs are dropped
    assign o_pop    = !r_busy && !i_queue_empty && (r_finished || out_free);

    assign cur_tile = r_busy ? r_tile : i_cmd.tile;
    assign cur_left = r_busy ? r_left : i_cmd.last_index;
    assign cur_clip = r_busy ? r_clip : i_cmd.clipped;
    assign last     = (cur_left == '0);

    always_comb begin
        if (i_cfg.col_count == 7'd0) begin
            eff_col = 8'd1;
        end else if ({1'b0, i_cfg.col_count} > 8'(MAX_COLS)) begin
            eff_col = 8'(MAX_COLS);
        end else begin
            eff_col = {1'b0, i_cfg.col_count};
        end
        if (i_cfg.row_count == 6'd0) begin
            eff_row = 7'd1;
        end else if ({1'b0, i_cfg.row_count} > 7'(MAX_ROWS)) begin
            eff_row = 7'(MAX_ROWS);
        end else begin
            eff_row = {1'b0, i_cfg.row_count};
        end
    end

    assign col_inc    = (r_column == 7'd127) ? r_column : r_column + 7'd1;
    assign row_end    = last && ({1'b0, col_inc} >= eff_col);
    assign map_last   = row_end && (({1'b0, r_row} + 7'd1) >= eff_row);
    assign next_start = r_row_start + 24'(i_cfg.row_stride);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_column    <= 7'd0;
            r_row       <= 6'd0;
            r_waddr     <= RST_BASE_ADDRESS;
            r_row_start <= RST_BASE_ADDRESS;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_restart.valid) begin
            r_busy      <= 1'b0;
            r_column    <= 7'd0;
            r_row       <= 6'd0;
            r_waddr     <= i_restart.base_address;
            r_row_start <= i_restart.base_address;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_busy      <= !last;
                r_out_valid <= 1'b1;
                if (row_end) begin
                    r_column    <= 7'd0;
                    r_waddr     <= next_start;
                    r_row_start <= next_start;
                    if (map_last) begin
                        r_finished <= 1'b1;
                    end else begin
                        r_row <= r_row + 6'd1;
                    end
                end else begin
                    r_column <= col_inc;
                    r_waddr  <= r_waddr + 24'd2;
                end
            end else if (i_tile_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_tile     <= cur_tile;
            r_left     <= cur_left - RUN_W'(1);
            r_clip     <= cur_clip;
            r_out_addr <= r_waddr;
            r_out_tile <= cur_tile;
            r_out_last <= last;
            r_out_done <= map_last;
            r_out_clip <= cur_clip;
        end
    end

    assign o_tile_valid   = r_out_valid;
    assign o_tile_address = r_out_addr;
    assign o_tile_word    = r_out_tile;
    assign o_run_last     = r_out_last;
    assign o_map_done     = r_out_done;
    assign o_run_clipped  = r_out_clip;

    `TMRLE_ASSERT_IMP(a_done_is_last, i_clk, i_rst_n, o_tile_valid && o_map_done, o_run_last)
    `TMRLE_ASSERT_IMP(a_done_sets_finished, i_clk, i_rst_n, o_tile_valid && o_map_done, r_finished)
    `TMRLE_ASSERT_IMP(a_no_run_after_map, i_clk, i_rst_n, r_finished, !r_busy)

endmodule

### sv/tilemap_rle_decoder_core.sv
// channel   | valid          | ready          | payload
// ----------+----------------+----------------+------------------------------------------
// map in    | i_map_valid    | o_map_ready    | i_map_word
// tile out  | o_tile_valid   | i_tile_ready   | o_tile_address, o_tile_word, o_run_last,
//           |                |                | o_map_done, o_run_clipped
// config    | i_cfg_we       | (none)         | i_cfg_index, i_cfg_data
//
// a literal word is pushed into the command queue and its tile leaves via the back
// end's output register; a run of count+1 copies leaves as count+1 tiles, one per
// cycle while i_tile_ready holds, so sustained rate is one tile per cycle, set by the
// single output write per cycle. escape and value words make no tile.
// the command queue (QUEUE_DEPTH entries) lets the front keep taking words while a
// run drains; the front stalls only when the queue is full.
// reset is synchronous active low; a base_address write restarts the map.
module tilemap_rle_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // encoded map request in
    input  logic        i_map_valid,
    output logic        o_map_ready,
    input  logic [15:0] i_map_word,
    // tile write request out
    output logic        o_tile_valid,
    input  logic        i_tile_ready,
    output logic [23:0] o_tile_address,
    output logic [15:0] o_tile_word,
    output logic        o_run_last,
    output logic        o_map_done,
    output logic        o_run_clipped,
    // register writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import tmrle_pkg::*;

    // config registers
    logic        r_compressed_mode;
    logic [5:0]  r_row_count;
    logic [6:0]  r_col_count;
    logic [10:0] r_row_stride;

    t_restart  restart;
    t_back_cfg back_cfg;

    // queue hookup
    logic push, pop, q_empty, q_full;
    t_cmd push_cmd, head_cmd;

    // a base address write restarts decoding at the new address
    assign restart.valid        = i_cfg_we && (i_cfg_index == REG_BASE_ADDRESS);
    assign restart.base_address = i_cfg_data;

    assign back_cfg.row_count  = r_row_count;
    assign back_cfg.col_count  = r_col_count;
    assign back_cfg.row_stride = r_row_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compressed_mode <= RST_COMPRESSED_MODE;
            r_row_count       <= RST_ROW_COUNT;
            r_col_count       <= RST_COL_COUNT;
            r_row_stride      <= RST_ROW_STRIDE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COMPRESSED_MODE: r_compressed_mode <= i_cfg_data[0];
                REG_ROW_COUNT:       r_row_count       <= i_cfg_data[5:0];
                REG_COL_COUNT:       r_col_count       <= i_cfg_data[6:0];
                REG_ROW_STRIDE:      r_row_stride      <= i_cfg_data[10:0];
                // base address is carried by the restart request
                default: ;
            endcase
        end
    end

    // front: token / value / count decoding into run commands
    tmrle_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_restart         (restart),
        .i_compressed_mode (r_compressed_mode),
        .i_map_valid       (i_map_valid),
        .i_map_word        (i_map_word),
        .o_map_ready       (o_map_ready),
        .i_queue_full      (q_full),
        .o_push            (push),
        .o_cmd             (push_cmd)
    );

    // short command queue between decode and tile writer
    tmrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (restart.valid),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: expands runs into addressed tile writes, tracks rows and columns
    tmrle_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (restart),
        .i_cfg          (back_cfg),
        .i_cmd          (head_cmd),
        .i_queue_empty  (q_empty),
        .o_pop          (pop),
        .o_tile_valid   (o_tile_valid),
        .i_tile_ready   (i_tile_ready),
        .o_tile_address (o_tile_address),
        .o_tile_word    (o_tile_word),
        .o_run_last     (o_run_last),
        .o_map_done     (o_map_done),
        .o_run_clipped  (o_run_clipped)
    );

endmodule
